FILE: sv/lcls_pkg.sv
// Shared types and constants for the LED cube layer scanner.
// No dependencies; imported by the controller, the datapath and the top level.
package lcls_pkg;

   localparam int CUBE_SIDE_DEF = 8;
   localparam int BYTE_W        = 8;
   localparam int COORD_W       = 3;
   localparam int FUNC_W        = 2;

   localparam logic [BYTE_W-1:0] ALL_DARK = 8'hFF;

   localparam logic [FUNC_W-1:0] FUNC_ROW  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LED  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SCAN = 2'd2;

   typedef struct packed {
      logic row_wr;
      logic led_rd;
      logic led_wr;
      logic scan_start;
      logic scan_issue;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic k_last;
   } status_type;

endpackage

FILE: sv/lcls_ctrl.sv
// Controller state machine of the LED cube layer scanner.
// Depends on lcls_pkg; drives datapath commands from input handshake and status.
module lcls_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [lcls_pkg::FUNC_W-1:0]        req_func,
   input  lcls_pkg::status_type               status,
   output lcls_pkg::cmd_type                  cmd
);
   import lcls_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LED  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FUNC_ROW: cmd.row_wr = 1'b1;
                  FUNC_LED: begin
                     cmd.led_rd = 1'b1;
                     state_in   = ST_LED;
                  end
                  FUNC_SCAN: begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_LED: begin
            cmd.led_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_SCAN: begin
            if (status.slot_free) begin
               cmd.scan_issue = 1'b1;
               if (status.k_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/lcls_dp.sv
// Datapath of the LED cube layer scanner: frame store, scan counters, result register.
// Depends on lcls_pkg; commanded by lcls_ctrl.
module lcls_dp #(
   parameter int CUBE_SIDE = lcls_pkg::CUBE_SIDE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lcls_pkg::cmd_type                  cmd,
   output lcls_pkg::status_type               status,
   input  logic [lcls_pkg::COORD_W-1:0]       req_led_x,
   input  logic [lcls_pkg::COORD_W-1:0]       req_row_y,
   input  logic [lcls_pkg::COORD_W-1:0]       req_layer_z,
   input  logic                               req_led_state,
   input  logic [lcls_pkg::BYTE_W-1:0]        req_line_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lcls_pkg::BYTE_W-1:0]        rsp_column_byte,
   output logic [lcls_pkg::COORD_W-1:0]       rsp_shift_position,
   output logic [lcls_pkg::COORD_W-1:0]       rsp_layer_select,
   output logic                               rsp_latch_last
);
   import lcls_pkg::*;

   localparam int DEPTH = CUBE_SIDE * CUBE_SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int KW    = $clog2(CUBE_SIDE);

   localparam logic [AW-1:0]      SIDE_A = AW'(CUBE_SIDE);
   localparam logic [COORD_W+1:0] SIDE_V = (COORD_W + 2)'(CUBE_SIDE);
   localparam logic [KW-1:0]      K_LAST = KW'(CUBE_SIDE - 1);

   logic [BYTE_W-1:0]  mem [DEPTH];
   logic [DEPTH-1:0]   vld_ff;

   logic [AW-1:0]      req_addr;
   logic [AW-1:0]      scan_addr;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   logic [BYTE_W-1:0]  wr_data;
   logic               wr_en;
   logic               coord_ok;
   logic               bit_ok;

   logic [AW-1:0]      led_addr_ff;
   logic [COORD_W-1:0] led_x_ff;
   logic               led_state_ff;
   logic               led_ok_ff;
   logic [BYTE_W-1:0]  rmw_byte_ff;
   logic               rmw_vld_ff;
   logic [BYTE_W-1:0]  led_base;
   logic [BYTE_W-1:0]  led_mask;
   logic [BYTE_W-1:0]  led_byte;

   logic [KW-1:0]      k_ff;
   logic [KW-1:0]      k_in;
   logic [COORD_W-1:0] layer_ff;
   logic [COORD_W-1:0] layer_in;
   logic [COORD_W+1:0] layer_inc;
   logic               k_last;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic               out_vld_ff;
   logic [COORD_W-1:0] shift_ff;
   logic [COORD_W-1:0] lsel_ff;
   logic               last_ff;

   assign coord_ok  = ({2'b00, req_row_y} < SIDE_V) && ({2'b00, req_layer_z} < SIDE_V);
   assign bit_ok    = ({2'b00, req_led_x} < SIDE_V);
   assign req_addr  = AW'(req_layer_z) * SIDE_A + AW'(req_row_y);
   assign scan_addr = AW'(layer_ff) * SIDE_A + AW'(k_ff);
   assign rd_addr   = cmd.scan_issue ? scan_addr : req_addr;

   assign led_base = rmw_vld_ff ? rmw_byte_ff : ALL_DARK;
   assign led_mask = BYTE_W'(1) << led_x_ff;
   assign led_byte = led_state_ff ? (led_base | led_mask) : (led_base & ~led_mask);

   assign wr_en   = (cmd.row_wr && coord_ok) || (cmd.led_wr && led_ok_ff);
   assign wr_addr = cmd.led_wr ? led_addr_ff : req_addr;
   assign wr_data = cmd.led_wr ? led_byte : req_line_value;

   // frame store: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.scan_issue) begin
         out_byte_ff <= mem[rd_addr];
         out_vld_ff  <= vld_ff[rd_addr];
         shift_ff    <= COORD_W'(k_ff);
         lsel_ff     <= layer_ff;
         last_ff     <= k_last;
      end else if (cmd.led_rd) begin
         rmw_byte_ff <= mem[rd_addr];
         rmw_vld_ff  <= vld_ff[rd_addr];
      end
      if (cmd.led_rd) begin
         led_addr_ff  <= req_addr;
         led_x_ff     <= req_led_x;
         led_state_ff <= req_led_state;
         led_ok_ff    <= coord_ok && bit_ok;
      end
   end

   // unwritten entries read as all dark
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign k_last    = (k_ff == K_LAST);
   assign layer_inc = {2'b00, layer_ff} + (COORD_W + 2)'(1);

   always_comb begin
      k_in     = k_ff;
      layer_in = layer_ff;
      if (cmd.scan_start) begin
         k_in = '0;
      end else if (cmd.scan_issue) begin
         if (k_last) begin
            k_in     = '0;
            layer_in = (layer_inc >= SIDE_V) ? '0 : layer_inc[COORD_W-1:0];
         end else begin
            k_in = k_ff + KW'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.scan_issue) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         layer_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         layer_ff     <= layer_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.slot_free = !rsp_valid_ff || !rsp_stall;
   assign status.k_last    = k_last;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_column_byte    = out_vld_ff ? out_byte_ff : ALL_DARK;
   assign rsp_shift_position = shift_ff;
   assign rsp_layer_select   = lsel_ff;
   assign rsp_latch_last     = last_ff;

endmodule

FILE: sv/led_cube_layer_scanner.sv
// Row write: a single write. LED write: read, modify, write back.
// Scan tick: CUBE_SIDE row bytes leave one a cycle while the output is not
// stalled, from the single frame store read port straight into the result register.
// Reset clears the layer index, the result valid and the per-entry valid bits;
// unwritten entries read as 0xFF. No clearing pass, items accepted right away.
// Top level: lcls_ctrl and lcls_dp, using lcls_pkg.
module led_cube_layer_scanner #(
   parameter int CUBE_SIDE = lcls_pkg::CUBE_SIDE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [lcls_pkg::FUNC_W-1:0]        req_func,
   input  logic [lcls_pkg::COORD_W-1:0]       req_led_x,
   input  logic [lcls_pkg::COORD_W-1:0]       req_row_y,
   input  logic [lcls_pkg::COORD_W-1:0]       req_layer_z,
   input  logic                               req_led_state,
   input  logic [lcls_pkg::BYTE_W-1:0]        req_line_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lcls_pkg::BYTE_W-1:0]        rsp_column_byte,
   output logic [lcls_pkg::COORD_W-1:0]       rsp_shift_position,
   output logic [lcls_pkg::COORD_W-1:0]       rsp_layer_select,
   output logic                               rsp_latch_last
);
   import lcls_pkg::*;

   cmd_type    cmd;
   status_type status;

   lcls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .status    (status),
      .cmd       (cmd)
   );

   lcls_dp #(.CUBE_SIDE(CUBE_SIDE)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_led_x          (req_led_x),
      .req_row_y          (req_row_y),
      .req_layer_z        (req_layer_z),
      .req_led_state      (req_led_state),
      .req_line_value     (req_line_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_column_byte    (rsp_column_byte),
      .rsp_shift_position (rsp_shift_position),
      .rsp_layer_select   (rsp_layer_select),
      .rsp_latch_last     (rsp_latch_last)
   );

endmodule

FILE: sv/lcls_checker.sv
// Port-level checks for the LED cube layer scanner, bound to the top level.
// Depends on lcls_pkg for field widths.
module lcls_checker #(
   parameter int CUBE_SIDE = lcls_pkg::CUBE_SIDE_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [lcls_pkg::BYTE_W-1:0]        rsp_column_byte,
   input logic [lcls_pkg::COORD_W-1:0]       rsp_shift_position,
   input logic [lcls_pkg::COORD_W-1:0]       rsp_layer_select,
   input logic                               rsp_latch_last
);
   import lcls_pkg::*;

   localparam logic [COORD_W-1:0] LAST_POS = COORD_W'(CUBE_SIDE - 1);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_column_byte)
         && $stable(rsp_shift_position) && $stable(rsp_layer_select)
         && $stable(rsp_latch_last))
      else $error("stalled result item changed");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_latch_last |-> rsp_shift_position == LAST_POS)
      else $error("latch mark not on final row byte");

   a_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_latch_last |=> rsp_valid)
      else $error("gap inside a layer scan");

   a_scan_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_latch_last |-> req_stall)
      else $error("input item accepted during a layer scan");

endmodule

bind led_cube_layer_scanner lcls_checker #(.CUBE_SIDE(CUBE_SIDE)) u_lcls_checker (.*);
